/* rtl/apef_pkg.sv */
`default_nettype none

package apef_pkg;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_PATH  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_ELEM     = 2'd0,
    KIND_PATH_END = 2'd1,
    KIND_ACK      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] as_num;
    logic [7:0]  seg_type;
    logic        seg_end;
    logic        full;
    logic        last;
  } res_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_status_t;

endpackage

`default_nettype wire

/* rtl/apef_scan.sv */
`default_nettype none

module apef_scan #(
  parameter int EXCL_DEPTH = 64,
  parameter int CW         = $clog2(EXCL_DEPTH + 1),
  parameter int AW         = (EXCL_DEPTH > 1) ? $clog2(EXCL_DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [31:0]           key_i,
  input  wire logic [CW-1:0]         count_i,
  input  wire logic                  wr_en_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire logic [31:0]           wr_data_i,
  output apef_pkg::scan_status_t     status_o
);
  import apef_pkg::*;

  logic [31:0]   mem [EXCL_DEPTH];
  logic [31:0]   rd_data_q;
  logic          busy_q, busy_d;
  logic          chk_q, chk_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rd_en;
  logic          match;

  assign rd_en = busy_q && (idx_q != count_i);
  assign match = chk_q && (rd_data_q == key_i);

  always_comb begin
    status_o.hit  = match;
    status_o.done = busy_q && (match || (!chk_q && (idx_q == count_i)));
  end

  always_comb begin
    busy_d = busy_q;
    chk_d  = rd_en;
    idx_d  = idx_q;
    if (start_i) begin
      busy_d = 1'b1;
      chk_d  = 1'b0;
      idx_d  = '0;
    end else if (status_o.done) begin
      busy_d = 1'b0;
      chk_d  = 1'b0;
    end else if (rd_en) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      chk_q  <= chk_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

/* rtl/as_path_exclude_filter.sv */
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  req_type, as_number, seg_type, seg_end, path_end
// out      output     out_valid_o/out_ready_i out_kind, out_as, out_seg_type, out_seg_end,
//                                            table_full, last
//
// An add or clear word is accepted and its acknowledgement is staged in the result buffer.
// A path word goes through the table scan, which stops at the first match or after count
// entries, where count is the number of stored exclusions; one comparator reads one table
// entry per cycle. Each result then passes the output register, held while the sink stalls.
// Reset clears the exclusion count and the pending element; table contents are not reset.
// The input is not ready while a word is being scanned or its results are being sent.

module as_path_exclude_filter #(
  parameter int EXCL_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] as_number_i,
  input  wire logic [7:0]  seg_type_i,
  input  wire logic        seg_end_i,
  input  wire logic        path_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [31:0]      out_as_o,
  output logic [7:0]       out_seg_type_o,
  output logic             out_seg_end_o,
  output logic             table_full_o,
  output logic             last_o
);
  import apef_pkg::*;

  localparam int CW = $clog2(EXCL_DEPTH + 1);
  localparam int AW = (EXCL_DEPTH > 1) ? $clog2(EXCL_DEPTH) : 1;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          pv_q, pv_d;
  logic [31:0]   pas_q, pas_d;
  logic [7:0]    ptype_q, ptype_d;
  logic [31:0]   as_q;
  logic [7:0]    st_q;
  logic          send_q, pend_q;
  res_t          res_q [3];
  res_t          res_d [3];
  logic [1:0]    res_cnt_q, res_cnt_d;
  logic [1:0]    res_idx_q, res_idx_d;
  logic [1:0]    path_n;
  res_t          out_q;
  logic          out_valid_q, out_valid_d;
  logic          accept;
  logic          full;
  logic          scan_start;
  logic          wr_en;
  logic          load;
  logic          last_slot;
  scan_status_t  scan_st;

  assign full       = (count_q == CW'(EXCL_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign last_slot  = (res_idx_q == (res_cnt_q - 2'd1));

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    scan_start = accept && (req_type_i == REQ_PATH);
    wr_en      = accept && (req_type_i == REQ_ADD) && !full;
    load       = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_ADD || req_type_i == REQ_CLEAR) begin
            state_d = ST_EMIT;
          end else if (req_type_i == REQ_PATH) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_st.done) begin
          state_d = (path_n != 2'd0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load && last_slot) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [1:0] n;
    n         = 2'd0;
    res_d     = res_q;
    res_cnt_d = res_cnt_q;
    res_idx_d = res_idx_q;
    count_d   = count_q;
    pv_d      = pv_q;
    pas_d     = pas_q;
    ptype_d   = ptype_q;
    if (accept) begin
      res_idx_d = 2'd0;
      case (req_type_i)
        REQ_ADD: begin
          res_d[0]      = '0;
          res_d[0].kind = KIND_ACK;
          res_d[0].full = full;
          res_d[0].last = 1'b1;
          res_cnt_d     = 2'd1;
          if (!full) begin
            count_d = count_q + CW'(1);
          end
        end
        REQ_CLEAR: begin
          res_d[0]      = '0;
          res_d[0].kind = KIND_ACK;
          res_d[0].last = 1'b1;
          res_cnt_d     = 2'd1;
          count_d       = '0;
        end
        default: ;
      endcase
    end
    if (state_q == ST_SCAN && scan_st.done) begin
      if (!scan_st.hit) begin
        if (pv_q) begin
          res_d[n]          = '0;
          res_d[n].kind     = KIND_ELEM;
          res_d[n].as_num   = pas_q;
          res_d[n].seg_type = ptype_q;
          n                 = n + 2'd1;
        end
        if (send_q) begin
          res_d[n]          = '0;
          res_d[n].kind     = KIND_ELEM;
          res_d[n].as_num   = as_q;
          res_d[n].seg_type = st_q;
          res_d[n].seg_end  = 1'b1;
          n                 = n + 2'd1;
          pv_d              = 1'b0;
        end else begin
          pv_d    = 1'b1;
          pas_d   = as_q;
          ptype_d = st_q;
        end
      end else if (send_q && pv_q) begin
        res_d[n]          = '0;
        res_d[n].kind     = KIND_ELEM;
        res_d[n].as_num   = pas_q;
        res_d[n].seg_type = ptype_q;
        res_d[n].seg_end  = 1'b1;
        n                 = n + 2'd1;
        pv_d              = 1'b0;
      end
      if (pend_q) begin
        res_d[n]      = '0;
        res_d[n].kind = KIND_PATH_END;
        n             = n + 2'd1;
      end
      if (n != 2'd0) begin
        res_d[n - 2'd1].last = 1'b1;
      end
      res_cnt_d = n;
    end
    if (load) begin
      res_idx_d = res_idx_q + 2'd1;
    end
    path_n = n;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pv_q        <= 1'b0;
      pas_q       <= '0;
      ptype_q     <= '0;
      res_cnt_q   <= '0;
      res_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pv_q        <= pv_d;
      pas_q       <= pas_d;
      ptype_q     <= ptype_d;
      res_cnt_q   <= res_cnt_d;
      res_idx_q   <= res_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      as_q   <= as_number_i;
      st_q   <= seg_type_i;
      send_q <= seg_end_i || path_end_i;
      pend_q <= path_end_i;
    end
    if (load) begin
      out_q <= res_q[res_idx_q];
    end
  end

  apef_scan #(
    .EXCL_DEPTH (EXCL_DEPTH),
    .CW         (CW),
    .AW         (AW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .key_i     (as_q),
    .count_i   (count_q),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (as_number_i),
    .status_o  (scan_st)
  );

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_q.kind;
  assign out_as_o       = out_q.as_num;
  assign out_seg_type_o = out_q.seg_type;
  assign out_seg_end_o  = out_q.seg_end;
  assign table_full_o   = out_q.full;
  assign last_o         = out_q.last;

  a_scan_done_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_st.done |-> state_q == ST_SCAN)
    else $error("scan finished outside the scan state");

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(EXCL_DEPTH))
    else $error("exclusion count beyond table depth");

  a_emit_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> res_cnt_q != 2'd0 && res_idx_q < res_cnt_q)
    else $error("result index out of range while sending");

  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == REQ_PATH |=> state_q == ST_SCAN)
    else $error("path word did not start a scan");

endmodule

`default_nettype wire
